FILE: sv/bfe_pkg.sv
// Shared types and constants for the bit field extractor.
// Depends on nothing; imported by bfe_extract and bit_field_extractor.
`default_nettype none

package bfe_pkg;

    // Buffer geometry. The buffer is held as rows of eight bytes, split over
    // two banks by row parity so that any two adjacent rows read together.
    localparam int BUFFER_BYTES  = 64;
    localparam int BITS_PER_BYTE = 8;
    localparam int ROW_BYTES     = 8;
    localparam int ROW_BITS      = ROW_BYTES * BITS_PER_BYTE;
    localparam int ROWS          = BUFFER_BYTES / ROW_BYTES;
    localparam int BANK_ROWS     = ROWS / 2;
    localparam int BANK_AW       = $clog2(BANK_ROWS);
    localparam int BUFFER_BITS   = BUFFER_BYTES * BITS_PER_BYTE;

    // Operation codes.
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // Result width codes.
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;

    typedef logic [ROW_BITS-1:0] row_t;

    // Extract request as it leaves the memory read stage.
    typedef struct packed {
        logic [5:0] bit_shift;     // bit position of the field inside the first row
        logic       row_odd;       // first row sits in the odd bank
        logic [6:0] bit_count;
        logic [1:0] result_width;
        logic       range_error;
    } bfe_req_t;

endpackage

`default_nettype wire

FILE: sv/bfe_ram.sv
// Generic single-write, single-read synchronous RAM with a bit write mask.
// The read data is registered. No dependencies.
`default_nettype none

module bfe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [WIDTH-1:0]         wmask,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                if (wmask[i])
                begin
                    mem[waddr][i] <= wdata[i];
                end
            end
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/bfe_extract.sv
// Field alignment, masking and byte swap stages of the bit field extractor.
// Depends on bfe_pkg; takes the two row words read from the buffer banks.
`default_nettype none

module bfe_extract (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire bfe_pkg::bfe_req_t req,
    input  wire bfe_pkg::row_t     even_row,
    input  wire bfe_pkg::row_t     odd_row,
    input  wire logic              swap_bytes,
    output logic                   result_valid,
    output logic [63:0]            field_value,
    output logic                   range_error
);

    import bfe_pkg::*;

    logic [2*ROW_BITS-1:0] window;
    logic [2*ROW_BITS-1:0] shifted;

    logic        align_valid_reg;
    logic        align_valid_next;
    logic [63:0] align_reg;
    logic [63:0] align_next;
    logic [6:0]  count_reg;
    logic [1:0]  width_reg;
    logic        error_reg;

    logic [63:0] right_value;
    logic [63:0] final_value;

    logic        result_valid_reg;
    logic [63:0] field_value_reg;
    logic [63:0] field_value_next;
    logic        range_error_reg;

    // The first row of the window is the one holding the field's first bit.
    always_comb
    begin
        window     = req.row_odd ? {odd_row, even_row} : {even_row, odd_row};
        shifted    = window << req.bit_shift;
        align_next = shifted[2*ROW_BITS-1 -: 64];
        align_valid_next = req_valid;
    end

    // A shift of 64 or more clears the value, which covers the empty field.
    always_comb
    begin
        right_value = align_reg >> (7'd64 - count_reg);
        final_value = right_value;
        if (swap_bytes)
        begin
            case (width_reg)
                WIDTH_16: final_value = {48'd0, right_value[7:0], right_value[15:8]};
                WIDTH_32: final_value = {32'd0, right_value[7:0], right_value[15:8],
                                         right_value[23:16], right_value[31:24]};
                WIDTH_64: final_value = {right_value[7:0],   right_value[15:8],
                                         right_value[23:16], right_value[31:24],
                                         right_value[39:32], right_value[47:40],
                                         right_value[55:48], right_value[63:56]};
                default:  final_value = right_value;
            endcase
        end
        field_value_next = error_reg ? 64'd0 : final_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            align_valid_reg  <= align_valid_next;
            result_valid_reg <= align_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        align_reg       <= align_next;
        count_reg       <= req.bit_count;
        width_reg       <= req.result_width;
        error_reg       <= req.range_error;
        field_value_reg <= field_value_next;
        range_error_reg <= error_reg;
    end

    assign result_valid = result_valid_reg;
    assign field_value  = field_value_reg;
    assign range_error  = range_error_reg;

endmodule

`default_nettype wire

FILE: sv/bit_field_extractor.sv
// Top level of the bit field extractor: request port, configuration register,
// buffer banks and assertions. Depends on bfe_pkg, bfe_ram and bfe_extract.
`default_nettype none

// The block keeps a 64-byte buffer and extracts MSB-first bit fields from it.
// A request is taken at every clock edge where start is high; busy is always
// low, so a new request may follow in every cycle. A write request stores one
// byte and gives no result. An extract request gives exactly one result, shown
// on field_value and range_error for one cycle with result_valid high; results
// come out in request order and the receiver cannot hold them off. Each extract
// passes in turn through the buffer read (both banks of eight-byte rows read at
// once, so any field of up to nine bytes comes in one access), the alignment
// shift, and the final mask and byte swap, each a registered stage. A write is
// visible to an extract taken in the next cycle. A field that is longer than
// the chosen width or runs past the buffer end returns range_error high and a
// value of zero. The swap_bytes register is set through the cfg channel, which
// is always ready, and should only be written while no extract is in flight.
// Bytes never written read as undefined.
module bit_field_extractor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        operation,
    input  wire logic [5:0]  byte_index,
    input  wire logic [7:0]  byte_value,
    input  wire logic [8:0]  bit_offset,
    input  wire logic [6:0]  bit_count,
    input  wire logic [1:0]  result_width,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    output logic             result_valid,
    output logic [63:0]      field_value,
    output logic             range_error
);

    import bfe_pkg::*;

    logic accept;
    logic write_req;
    logic extract_req;

    logic swap_reg;
    logic swap_next;

    // Write side of the banks.
    logic               even_we;
    logic               odd_we;
    logic [BANK_AW-1:0] waddr;
    row_t               wdata;
    row_t               wmask;

    // Read side of the banks.
    logic [2:0]         first_row;
    logic [BANK_AW-1:0] even_raddr;
    logic [BANK_AW-1:0] odd_raddr;
    row_t               even_row;
    row_t               odd_row;

    logic [9:0]  field_end;
    logic [6:0]  width_bits;

    logic        req_valid_reg;
    logic        req_valid_next;
    bfe_req_t    req_reg;
    bfe_req_t    req_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign write_req   = accept && (operation == OP_WRITE);
    assign extract_req = accept && (operation == OP_EXTRACT);

    assign swap_next = (cfg_valid && cfg_ready) ? cfg_data : swap_reg;

    // Byte i lives in row i/8, lane i%8, with lane 0 in the row's top byte.
    // Even rows go to one bank and odd rows to the other.
    always_comb
    begin
        waddr   = byte_index[5:4];
        even_we = write_req && !byte_index[3];
        odd_we  = write_req && byte_index[3];
        wdata   = {ROW_BYTES{byte_value}};
        wmask   = {8'hFF, {(ROW_BITS-8){1'b0}}} >> {byte_index[2:0], 3'b000};
    end

    // The field's first row and the row after it sit in different banks.
    // Past the last row the second read wraps; those bits are never used.
    always_comb
    begin
        first_row  = bit_offset[8:6];
        even_raddr = first_row[2:1] + BANK_AW'(first_row[0]);
        odd_raddr  = first_row[2:1];
    end

    always_comb
    begin
        field_end  = {1'b0, bit_offset} + {3'b000, bit_count};
        width_bits = 7'(BITS_PER_BYTE) << result_width;

        req_valid_next        = extract_req;
        req_next.bit_shift    = bit_offset[5:0];
        req_next.row_odd      = first_row[0];
        req_next.bit_count    = bit_count;
        req_next.result_width = result_width;
        req_next.range_error  = (bit_count > width_bits) ||
                                (field_end > 10'(BUFFER_BITS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg      <= 1'b0;
            req_valid_reg <= 1'b0;
        end
        else
        begin
            swap_reg      <= swap_next;
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    bfe_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (BANK_ROWS)
    ) u_even_bank (
        .clk   (clk),
        .we    (even_we),
        .waddr (waddr),
        .wdata (wdata),
        .wmask (wmask),
        .raddr (even_raddr),
        .rdata (even_row)
    );

    bfe_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (BANK_ROWS)
    ) u_odd_bank (
        .clk   (clk),
        .we    (odd_we),
        .waddr (waddr),
        .wdata (wdata),
        .wmask (wmask),
        .raddr (odd_raddr),
        .rdata (odd_row)
    );

    bfe_extract u_extract (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid_reg),
        .req          (req_reg),
        .even_row     (even_row),
        .odd_row      (odd_row),
        .swap_bytes   (swap_reg),
        .result_valid (result_valid),
        .field_value  (field_value),
        .range_error  (range_error)
    );

    // Every result traces back to an extract request taken earlier.
    a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy && (operation == OP_EXTRACT), 3))
        else $error("result without an extract request");

    // A flagged result always carries a zero value.
    a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && range_error) |-> (field_value == 64'd0))
        else $error("range error with a nonzero value");

    // A count beyond any result width must come back flagged.
    a_long_count_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_EXTRACT) && (bit_count > 7'd64))
        |-> ##3 (result_valid && range_error))
        else $error("oversized count not flagged");

endmodule

`default_nettype wire
